[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

[rtl/qrs_pkg.sv]
// Shared types for the quadratic root solver.
package qrs_pkg;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_t;

endpackage

[rtl/qrs_front.sv]
// Front end: capture coefficients, form products and the discriminant.
module qrs_front #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [W-1:0]          a_in,
  input  logic [W-1:0]          b_in,
  input  logic [W-1:0]          c_in,
  output logic                  out_valid,
  output logic [2*W+1:0]        disc,
  output qrs_pkg::status_t      status,
  output logic                  aneg,
  output logic [W-1:0]          amag,
  output logic                  bneg,
  output logic [W-1:0]          bmag
);
  import qrs_pkg::*;

  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;

  logic         v1;
  logic [W-1:0] a1, b1, c1;

  logic          v2, an2, bn2, cn2, az2;
  logic [W-1:0]  am2, bm2;
  logic [PW-1:0] b2, ac;

  logic         an1, bn1, cn1;
  logic [W-1:0] am1, bm1, cm1;

  logic [DW-1:0] b2e, ac4, sum, diff, d_next;
  status_t       st_next;

  always_comb begin
    an1 = a1[W-1];
    bn1 = b1[W-1];
    cn1 = c1[W-1];
    am1 = an1 ? (~a1 + 1'b1) : a1;
    bm1 = bn1 ? (~b1 + 1'b1) : b1;
    cm1 = cn1 ? (~c1 + 1'b1) : c1;
  end

  always_comb begin
    b2e  = DW'(b2);
    ac4  = {ac, 2'b00};
    sum  = b2e + ac4;
    diff = b2e - ac4;
    d_next = '0;
    priority if (az2) begin
      st_next = ST_AZERO;
    end else if (an2 != cn2) begin
      d_next  = sum;
      st_next = (sum != '0) ? ST_TWO : ST_ONE;
    end else if (b2e < ac4) begin
      st_next = ST_NONE;
    end else begin
      d_next  = diff;
      st_next = (diff != '0) ? ST_TWO : ST_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    a1  <= a_in;
    b1  <= b_in;
    c1  <= c_in;
    an2 <= an1;
    bn2 <= bn1;
    cn2 <= cn1;
    az2 <= (a1 == '0);
    am2 <= am1;
    bm2 <= bm1;
    b2  <= PW'(bm1) * PW'(bm1);
    ac  <= PW'(am1) * PW'(cm1);
    disc   <= d_next;
    status <= st_next;
    aneg   <= an2;
    amag   <= am2;
    bneg   <= bn2;
    bmag   <= bm2;
  end

endmodule

[rtl/qrs_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*W+1:0]    d_in,
  input  logic [SW-1:0]     side_in,
  output logic              out_valid,
  output logic [W:0]        root,
  output logic [SW-1:0]     side_out
);
  localparam int DW = 2 * W + 2;
  localparam int RW = W + 1;

  logic          v_s [0:RW];
  logic [DW-1:0] d_s [0:RW];
  logic [RW+1:0] r_s [0:RW];
  logic [RW-1:0] q_s [0:RW];
  logic [SW-1:0] x_s [0:RW];

  assign v_s[0] = in_valid;
  assign d_s[0] = d_in;
  assign r_s[0] = '0;
  assign q_s[0] = '0;
  assign x_s[0] = side_in;

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RW+1:0] rs, trial;
    logic          ge;
    always_comb begin
      rs    = {r_s[i][RW-1:0], d_s[i][DW-1 -: 2]};
      trial = {q_s[i], 2'b01};
      ge    = (rs >= trial);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else begin
        v_s[i+1] <= v_s[i];
      end
      d_s[i+1] <= d_s[i] << 2;
      r_s[i+1] <= ge ? (rs - trial) : rs;
      q_s[i+1] <= {q_s[i][RW-2:0], ge};
      x_s[i+1] <= x_s[i];
    end
  end

  assign out_valid = v_s[RW];
  assign root      = q_s[RW];
  assign side_out  = x_s[RW];

endmodule

[rtl/qrs_div.sv]
// Pipelined restoring divider for one root, with clamp and sign.
module qrs_div #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic           clk,
  input  logic           nneg,
  input  logic [W+1:0]   nmag,
  input  logic           aneg,
  input  logic [W-1:0]   amag,
  output logic [W-1:0]   root,
  output logic           sat
);
  localparam int NW = W + 2 + F;
  localparam int CW = 2 * W + F + 3;

  logic [NW-1:0] numer, hi;
  logic [W:0]    den;
  logic          ovf;

  always_comb begin
    numer = {nmag, {F{1'b0}}};
    den   = {amag, 1'b0};
    ovf   = (CW'(numer) >= (CW'(den) << W));
    hi    = numer >> W;
  end

  logic [W:0]   den_s [0:W];
  logic [W:0]   rem_s [0:W];
  logic [W-1:0] q_s   [0:W];
  logic [W-1:0] lo_s  [0:W];
  logic         neg_s [0:W];
  logic         ovf_s [0:W];

  always_ff @(posedge clk) begin
    den_s[0] <= den;
    rem_s[0] <= hi[W:0];
    q_s[0]   <= '0;
    lo_s[0]  <= numer[W-1:0];
    neg_s[0] <= nneg ^ aneg;
    ovf_s[0] <= ovf;
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    logic [W+1:0] rs, diff;
    logic         ge;
    always_comb begin
      rs   = {rem_s[j], lo_s[j][W-1]};
      diff = rs - {1'b0, den_s[j]};
      ge   = (rs >= {1'b0, den_s[j]});
    end
    always_ff @(posedge clk) begin
      den_s[j+1] <= den_s[j];
      rem_s[j+1] <= ge ? diff[W:0] : rs[W:0];
      q_s[j+1]   <= {q_s[j][W-2:0], ge};
      lo_s[j+1]  <= lo_s[j] << 1;
      neg_s[j+1] <= neg_s[j];
      ovf_s[j+1] <= ovf_s[j];
    end
  end

  logic [W-1:0] lim, mag;
  logic         clamp;

  always_comb begin
    lim   = neg_s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    clamp = ovf_s[W] || (q_s[W] > lim);
    mag   = clamp ? lim : q_s[W];
  end

  always_ff @(posedge clk) begin
    root <= neg_s[W] ? (~mag + 1'b1) : mag;
    sat  <= clamp;
  end

endmodule

[rtl/quadratic_root_solver_top.sv]
// Top level of the quadratic root solver pipeline.
// Takes one equation word per cycle (busy is always low) and returns its result,
// marked by done for one cycle. The depth comes mostly from the square root
// (COEF_WIDTH+1 stages, one bit each) and the divider (COEF_WIDTH+2 stages, one
// quotient bit each but the input and output registers); results cannot be
// held off, so the receiver must take every done cycle.
`include "assert_macros.svh"
module quadratic_root_solver_top #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COEF_WIDTH-1:0] coef_a,
  input  logic [COEF_WIDTH-1:0] coef_b,
  input  logic [COEF_WIDTH-1:0] coef_c,
  output logic                  done,
  output logic [1:0]            root_status,
  output logic [COEF_WIDTH-1:0] root_plus,
  output logic [COEF_WIDTH-1:0] root_minus,
  output logic                  saturated
);
  import qrs_pkg::*;

  localparam int W   = COEF_WIDTH;
  localparam int SW  = 2 * W + 4;
  localparam int DL  = W + 2;
  localparam int LAT = 2 * W + 8;

  assign busy = 1'b0;

  logic          f_v, f_an, f_bn;
  logic [2*W+1:0] f_d;
  status_t       f_st;
  logic [W-1:0]  f_am, f_bm;

  qrs_front #(.W(W)) u_front (
    .clk(clk), .rst(rst), .in_valid(start),
    .a_in(coef_a), .b_in(coef_b), .c_in(coef_c),
    .out_valid(f_v), .disc(f_d), .status(f_st),
    .aneg(f_an), .amag(f_am), .bneg(f_bn), .bmag(f_bm)
  );

  logic          s_v;
  logic [W:0]    s_root;
  logic [SW-1:0] s_side;

  qrs_sqrt #(.W(W), .SW(SW)) u_sqrt (
    .clk(clk), .rst(rst), .in_valid(f_v), .d_in(f_d),
    .side_in({f_st, f_an, f_am, f_bn, f_bm}),
    .out_valid(s_v), .root(s_root), .side_out(s_side)
  );

  logic [1:0]   q_st;
  logic         q_an, q_bn, xneg;
  logic [W-1:0] q_am, q_bm;
  logic [W+1:0] xm, sm, pm_next, mm_next;
  logic         pn_next, mn_next;

  always_comb begin
    {q_st, q_an, q_am, q_bn, q_bm} = s_side;
    xneg = !q_bn;
    xm   = (W+2)'(q_bm);
    sm   = (W+2)'(s_root);
    // plus root: -b + s
    priority if (!xneg) begin
      pn_next = 1'b0; pm_next = xm + sm;
    end else if (xm >= sm) begin
      pn_next = 1'b1; pm_next = xm - sm;
    end else begin
      pn_next = 1'b0; pm_next = sm - xm;
    end
    // minus root: -b - s
    priority if (xneg) begin
      mn_next = 1'b1; mm_next = xm + sm;
    end else if (xm >= sm) begin
      mn_next = 1'b0; mm_next = xm - sm;
    end else begin
      mn_next = 1'b1; mm_next = sm - xm;
    end
  end

  logic         n_v, n_pn, n_mn, n_an;
  logic [1:0]   n_st;
  logic [W+1:0] n_pm, n_mm;
  logic [W-1:0] n_am;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else begin
      n_v <= s_v;
    end
    n_st <= q_st;
    n_pn <= pn_next;
    n_pm <= pm_next;
    n_mn <= mn_next;
    n_mm <= mm_next;
    n_an <= q_an;
    n_am <= q_am;
  end

  logic [W-1:0] rp, rm;
  logic         sp, smi;

  qrs_div #(.W(W), .F(FRAC_BITS)) u_div_plus (
    .clk(clk), .nneg(n_pn), .nmag(n_pm), .aneg(n_an), .amag(n_am),
    .root(rp), .sat(sp)
  );

  qrs_div #(.W(W), .F(FRAC_BITS)) u_div_minus (
    .clk(clk), .nneg(n_mn), .nmag(n_mm), .aneg(n_an), .amag(n_am),
    .root(rm), .sat(smi)
  );

  // status and valid ride alongside the dividers
  logic       dv [0:DL];
  logic [1:0] dst [0:DL];

  assign dv[0]  = n_v;
  assign dst[0] = n_st;

  for (genvar k = 0; k < DL; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dst[k+1] <= dst[k];
    end
  end

  status_t st_o;
  assign st_o = status_t'(dst[DL]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DL];
    end
    root_status <= dst[DL];
    unique case (st_o)
      ST_TWO: begin
        root_plus  <= rp;
        root_minus <= rm;
        saturated  <= sp | smi;
      end
      ST_ONE: begin
        root_plus  <= rp;
        root_minus <= '0;
        saturated  <= sp;
      end
      default: begin
        root_plus  <= '0;
        root_minus <= '0;
        saturated  <= 1'b0;
      end
    endcase
  end

  `ASSERT_NEVER(a_never_busy, clk, rst, busy)
  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, LAT, done)
  `ASSERT_IMPL(a_no_root_zero, clk, rst, done && (root_status == ST_AZERO || root_status == ST_NONE), root_plus == '0 && root_minus == '0 && !saturated)
  `ASSERT_IMPL(a_one_root_minus, clk, rst, done && root_status == ST_ONE, root_minus == '0)

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the quadratic root solver pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qrs_pkg::*;

  localparam int FRAC      = 16;
  localparam int LATENCY   = 72;
  localparam int MAX_CYCLE = 300000;

  typedef struct {
    status_t     status;
    logic [31:0] rplus;
    logic [31:0] rminus;
    logic        sat;
  } roots_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] coef_a = '0, coef_b = '0, coef_c = '0;
  logic        done;
  logic [1:0]  root_status;
  logic [31:0] root_plus, root_minus;
  logic        saturated;

  roots_t pending_roots[$];
  int     mismatches = 0;
  int     cycles = 0;
  int     send_idle_pct = 0;

  quadratic_root_solver_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done), .root_status(root_status), .root_plus(root_plus),
    .root_minus(root_minus), .saturated(saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [127:0] isqrt(input logic [127:0] d);
    logic [127:0] r, cand;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (128'd1 << i);
      if (cand * cand <= d) r = cand;
    end
    return r;
  endfunction

  // Quotient (n * 2^FRAC) / (2a), truncated toward zero, clamped to 32 bits.
  function automatic logic [31:0] scaled_root(input logic signed [127:0] n,
                                              input logic signed [127:0] a,
                                              output logic clamped);
    logic [127:0] nm, am, q, lim;
    logic neg;
    nm = (n < 0) ? -n : n;
    am = (a < 0) ? -a : a;
    q = (nm << FRAC) / (am << 1);
    neg = (n < 0) ^ (a < 0);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    clamped = 1'b0;
    if (q > lim) begin
      q = lim;
      clamped = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic roots_t solve_quadratic(input logic [31:0] a, b, c);
    roots_t r;
    logic signed [127:0] sa, sb, sc, disc, s;
    logic c1, c2;
    sa = $signed(a);
    sb = $signed(b);
    sc = $signed(c);
    r = '{ST_TWO, '0, '0, 1'b0};
    if (sa == 0) begin
      r.status = ST_AZERO;
      return r;
    end
    disc = sb * sb - 4 * sa * sc;
    if (disc < 0) begin
      r.status = ST_NONE;
    end else if (disc == 0) begin
      r.status = ST_ONE;
      r.rplus = scaled_root(-sb, sa, c1);
      r.sat = c1;
    end else begin
      s = isqrt(disc);
      r.rplus = scaled_root(-sb + s, sa, c1);
      r.rminus = scaled_root(-sb - s, sa, c2);
      r.sat = c1 | c2;
    end
    return r;
  endfunction

  // Record accepted words and check each done word against the oldest one.
  always @(posedge clk) begin
    roots_t want;
    cycles <= cycles + 1;
    if (!rst && start && !busy) pending_roots.push_back(solve_quadratic(coef_a, coef_b, coef_c));
    if (!rst && done) begin
      if (pending_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        want = pending_roots.pop_front();
        if (root_status !== want.status || root_plus !== want.rplus ||
            root_minus !== want.rminus || saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d p=%h m=%h s=%b got st=%0d p=%h m=%h s=%b",
                     want.status, want.rplus, want.rminus, want.sat,
                     root_status, root_plus, root_minus, saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > MAX_CYCLE) begin
      $display("quadratic_root_solver_top verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] a, b, c);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_directed();
    send_word(32'h0, 32'h0001_0000, 32'h0001_0000);          // zero a
    send_word(32'h0, 32'hffff_ffff, 32'h8000_0000);
    send_word(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);  // roots 2 and 1
    send_word(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);  // double root
    send_word(32'h0001_0000, 32'h0, 32'h0001_0000);          // complex pair
    send_word(32'h0000_0001, 32'h7fff_ffff, 32'h0);          // clamp low
    send_word(32'h0000_0001, 32'h8000_0000, 32'h0);          // clamp high
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_word(32'hffff_ffff, 32'h0, 32'h0);                  // zero discriminant
    send_word(32'h7fff_ffff, 32'h0000_0001, 32'h0);          // tiny root
    send_word(32'hffff_0000, 32'h0, 32'h0004_0000);          // roots +-2, a negative
    send_word(32'h0001_0000, 32'h0, 32'h0);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(input int count);
    longint a, r1, r2;
    logic [31:0] b, c;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_word($urandom, $urandom, $urandom);
        1: begin
          // integer-ish roots, usually in range
          a = longint'($urandom_range(8192)) - 4096;
          r1 = longint'($urandom_range(2000)) - 1000;
          r2 = ($urandom_range(3) == 0) ? r1 : longint'($urandom_range(2000)) - 1000;
          b = 32'(-a * (r1 + r2));
          c = 32'(a * r1 * r2);
          send_word(32'(a), b, c);
        end
        2: send_word(32'($urandom_range(65536 * 16)) - 32'd524288,
                     32'($urandom_range(65536 * 64)) - 32'd2097152,
                     32'($urandom_range(65536 * 64)) - 32'd2097152);
        default: send_word($urandom_range(15) == 0 ? 32'h0 : 32'($urandom_range(255)),
                           $urandom, $urandom_range(65535));
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 21;
    test_directed();
    test_random(140);
    send_idle_pct = 77;
    test_random(145);
    send_idle_pct = 0;
    test_random(150);
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_roots.size() == 0)
      $display("quadratic_root_solver_top verification clean");
    else
      $display("quadratic_root_solver_top verification failed");
    $finish;
  end
endmodule

[quadratic_root_solver_top.f]
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_front.sv
rtl/qrs_sqrt.sv
rtl/qrs_div.sv
rtl/quadratic_root_solver_top.sv
bench/tb_top.sv
